// ===== rtl/core/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the page bitmap allocator: operation and
// status codes, transfer payloads, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pba_pkg;

  // bits per used-map word and bits of the page offset inside a word
  localparam int WORD_BITS  = 32;
  localparam int WORD_IDX_W = 5;

  // memory size register value after reset
  localparam logic [31:0] MEM_BYTES_RESET = 32'd134217728;

  typedef enum logic [1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOMEM  = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] page_address;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] alloc_address;
    logic [15:0] free_count;
    logic [15:0] total_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INIT_START,
    ST_INIT_DIV,
    ST_SWEEP,
    ST_FREE_START,
    ST_FREE_DIV,
    ST_FREE_WAIT,
    ST_FREE_CHK,
    ST_ALLOC_WAIT,
    ST_ALLOC_CHK,
    ST_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    div_start;
    logic    div_use_addr;
    logic    init_load;
    logic    sweep_wr;
    logic    ptr_hint;
    logic    ptr_free;
    logic    ptr_next;
    logic    free_commit;
    logic    alloc_commit;
    logic    res_set;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  div_done;
    logic  sweep_last;
    logic  free_in_range;
    logic  page_used;
    logic  cand_any;
    logic  scan_last;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/pba_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_div
// Division by a fixed divisor through a scaled reciprocal: the partial
// products are registered first, then their sum and the quotient; done
// pulses once when the quotient is ready.
// ----------------------------------------------------------------------------
module pba_div #(
  parameter int DIVISOR = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  output logic             done,
  output logic [31:0]      quotient
);
  // reciprocal rounded up, exact for every 32-bit dividend
  localparam int          SH       = $clog2(DIVISOR);
  localparam logic [63:0] RECIP    = ((64'd1 << (32 + SH)) + 64'(DIVISOR) - 64'd1) /
                                     64'(DIVISOR);
  localparam logic [16:0] RECIP_LO = 17'(RECIP);
  localparam logic [15:0] RECIP_HI = 16'(RECIP >> 17);

  logic        step_r, step_nxt;
  logic        done_r, done_nxt;
  logic [48:0] plo_r, plo_nxt;
  logic [47:0] phi_r, phi_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [64:0] prod_sum;

  // partial products of the dividend and the reciprocal halves
  always_comb begin
    step_nxt = start;
    plo_nxt  = plo_r;
    phi_nxt  = phi_r;
    if (start) begin
      plo_nxt = 49'(dividend) * 49'(RECIP_LO);
      phi_nxt = 48'(dividend) * 48'(RECIP_HI);
    end
  end

  // full product, quotient in its top bits
  always_comb begin
    prod_sum = 65'(plo_r) + (65'(phi_r) << 17);
    done_nxt = step_r;
    quo_nxt  = step_r ? 32'(prod_sum >> (32 + SH)) : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/core/pba_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_dp
// Allocator datapath: memory size register, item register, used-map memory
// with registered read, word pointer and search hint, page counters, page
// divider, result holding and the output register.
// ----------------------------------------------------------------------------
module pba_dp #(
  parameter int NUM_PAGES      = 32768,
  parameter int PAGE_BYTES     = 4096,
  parameter int RESERVED_PAGES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire pba_pkg::in_item_t in_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output pba_pkg::out_item_t     out_data,
  input  wire pba_pkg::cmd_t     cmd,
  output pba_pkg::sts_t          sts
);
  import pba_pkg::*;

  localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(NUM_PAGES + 1);
  localparam int XW        = PW + 1;
  localparam int RES_EFF   = (RESERVED_PAGES < NUM_PAGES) ? RESERVED_PAGES : NUM_PAGES;
  localparam int HINT0     = ((RES_EFF / WORD_BITS) < MAP_WORDS) ?
                             (RES_EFF / WORD_BITS) : (MAP_WORDS - 1);
  localparam int PGW       = WW + WORD_IDX_W;
  localparam int PRW       = (PGW + 17 > 32) ? (PGW + 17) : 32;

  logic [31:0]          mem_bytes_r;
  in_item_t             item_r;
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WW-1:0]        ptr_r, ptr_nxt;
  logic [WW-1:0]        hint_r, hint_nxt;
  logic [PW-1:0]        managed_r, managed_nxt;
  logic [PW-1:0]        free_r, free_nxt;
  status_t              res_status_r;
  logic                 res_has_addr_r;
  logic [PGW-1:0]       res_page_r;
  out_item_t            out_r;
  logic                 out_valid_r;

  logic [31:0]          div_dividend;
  logic                 div_done;
  logic [31:0]          quotient;
  logic [PW-1:0]        q_clamp;
  logic [WW-1:0]        q_word;
  logic [4:0]           q_bit;

  logic [XW-1:0]        base, lo, hi;
  logic [5:0]           lo_off, hi_off;
  logic [WORD_BITS-1:0] ones, mask, cand, cand_low;
  logic [4:0]           cand_idx;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [PRW-1:0]       addr_prod;

  // page index of a byte address or of the memory size
  assign div_dividend = cmd.div_use_addr ? item_r.page_address : mem_bytes_r;

  pba_div #(
    .DIVISOR (PAGE_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    q_clamp = (quotient > 32'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(quotient);
    q_word  = quotient[PGW-1:WORD_IDX_W];
    q_bit   = quotient[WORD_IDX_W-1:0];
  end

  // pages of the current word that lie in the allocatable range
  always_comb begin
    base   = XW'({ptr_r, WORD_IDX_W'(0)});
    lo     = XW'(RES_EFF);
    hi     = XW'(managed_r);
    if (lo <= base) begin
      lo_off = '0;
    end else if (lo - base >= XW'(WORD_BITS)) begin
      lo_off = 6'(WORD_BITS);
    end else begin
      lo_off = 6'(lo - base);
    end
    if (hi <= base) begin
      hi_off = '0;
    end else if (hi - base >= XW'(WORD_BITS)) begin
      hi_off = 6'(WORD_BITS);
    end else begin
      hi_off = 6'(hi - base);
    end
    ones = '1;
    mask = (ones << lo_off) & ~(ones << hi_off);
  end

  // lowest free page in the word just read
  always_comb begin
    cand     = ~rd_data_r & mask;
    cand_low = cand & (~cand + WORD_BITS'(1));
    cand_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (cand_low[i]) begin
        cand_idx = cand_idx | 5'(i);
      end
    end
  end

  // map write data
  always_comb begin
    wr_en   = cmd.sweep_wr | cmd.free_commit | cmd.alloc_commit;
    wr_data = rd_data_r;
    priority if (cmd.sweep_wr) begin
      wr_data = ~mask;
    end else if (cmd.free_commit) begin
      wr_data = rd_data_r & ~(WORD_BITS'(1) << q_bit);
    end else if (cmd.alloc_commit) begin
      wr_data = rd_data_r | cand_low;
    end
  end

  // used map, one port each way, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[ptr_r] <= wr_data;
    end
    rd_data_r <= map_mem[ptr_r];
  end

  // pointer, hint and counters
  always_comb begin
    ptr_nxt     = ptr_r;
    hint_nxt    = hint_r;
    managed_nxt = managed_r;
    free_nxt    = free_r;
    if (cmd.init_load) begin
      ptr_nxt     = '0;
      hint_nxt    = WW'(HINT0);
      managed_nxt = q_clamp;
      free_nxt    = (q_clamp > PW'(RES_EFF)) ? q_clamp - PW'(RES_EFF) : '0;
    end
    if (cmd.sweep_wr || cmd.ptr_next) begin
      ptr_nxt = ptr_r + WW'(1);
    end
    if (cmd.ptr_hint) begin
      ptr_nxt = hint_r;
    end
    if (cmd.ptr_free) begin
      ptr_nxt = q_word;
    end
    if (cmd.free_commit) begin
      free_nxt = free_r + PW'(1);
      if (q_word < hint_r) begin
        hint_nxt = q_word;
      end
    end
    if (cmd.alloc_commit) begin
      free_nxt = free_r - PW'(1);
      hint_nxt = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r <= MEM_BYTES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mem_bytes_r <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    hint_r    <= hint_nxt;
    managed_r <= managed_nxt;
    free_r    <= free_nxt;
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.res_set) begin
      res_status_r   <= cmd.res_status;
      res_has_addr_r <= cmd.alloc_commit;
    end
    if (cmd.alloc_commit) begin
      res_page_r <= {ptr_r, cand_idx};
    end
    if (cmd.out_load) begin
      out_r.status        <= res_status_r;
      out_r.alloc_address <= res_has_addr_r ? addr_prod[31:0] : '0;
      out_r.free_count    <= 16'(free_r);
      out_r.total_count   <= 16'(managed_r);
    end
  end

  // byte address of the allocated page
  assign addr_prod = PRW'(res_page_r) * PRW'(PAGE_BYTES);

  // status toward the controller
  always_comb begin
    sts.func          = item_r.func;
    sts.div_done      = div_done;
    sts.sweep_last    = ptr_r == WW'(MAP_WORDS - 1);
    sts.free_in_range = quotient < 32'(managed_r);
    sts.page_used     = rd_data_r[q_bit];
    sts.cand_any      = |cand;
    sts.scan_last     = (base + XW'(WORD_BITS) >= hi) || (ptr_r == WW'(MAP_WORDS - 1));
    sts.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/pba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_ctrl
// Allocator controller: sequences init (divide, map sweep), allocate (word
// scan from the hint), free (divide, read, clear) and the result handoff.
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output pba_pkg::cmd_t      cmd,
  input  wire pba_pkg::sts_t sts
);
  import pba_pkg::*;

  state_t state_r, state_nxt;
  logic   reply_r, reply_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.func)
          FUNC_INIT: begin
            state_nxt = ST_INIT_START;
            reply_nxt = 1'b1;
          end
          FUNC_ALLOC: state_nxt = ST_ALLOC_WAIT;
          FUNC_FREE:  state_nxt = ST_FREE_START;
          FUNC_NOP:   state_nxt = ST_RESP;
        endcase
      end
      ST_INIT_START: state_nxt = ST_INIT_DIV;
      ST_INIT_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sts.sweep_last) begin
          state_nxt = reply_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_FREE_START: state_nxt = ST_FREE_DIV;
      ST_FREE_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.free_in_range ? ST_FREE_WAIT : ST_RESP;
        end
      end
      ST_FREE_WAIT: state_nxt = ST_FREE_CHK;
      ST_FREE_CHK:  state_nxt = ST_RESP;
      ST_ALLOC_WAIT: state_nxt = ST_ALLOC_CHK;
      ST_ALLOC_CHK: begin
        if (sts.cand_any || sts.scan_last) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_ALLOC_WAIT;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.res_status = STAT_OK;
    in_ready       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DECODE: begin
        unique case (sts.func)
          FUNC_ALLOC: cmd.ptr_hint = 1'b1;
          FUNC_NOP: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = STAT_OK;
          end
          FUNC_INIT, FUNC_FREE: ;
        endcase
      end
      ST_INIT_START: cmd.div_start = 1'b1;
      ST_INIT_DIV:   cmd.init_load = sts.div_done;
      ST_SWEEP: begin
        cmd.sweep_wr   = 1'b1;
        cmd.res_set    = sts.sweep_last && reply_r;
        cmd.res_status = STAT_OK;
      end
      ST_FREE_START: begin
        cmd.div_start    = 1'b1;
        cmd.div_use_addr = 1'b1;
      end
      ST_FREE_DIV: begin
        if (sts.div_done) begin
          cmd.ptr_free   = sts.free_in_range;
          cmd.res_set    = !sts.free_in_range;
          cmd.res_status = STAT_REJECT;
        end
      end
      ST_FREE_WAIT: ;
      ST_FREE_CHK: begin
        cmd.free_commit = sts.page_used;
        cmd.res_set     = 1'b1;
        cmd.res_status  = sts.page_used ? STAT_OK : STAT_REJECT;
      end
      ST_ALLOC_WAIT: ;
      ST_ALLOC_CHK: begin
        if (sts.cand_any) begin
          cmd.alloc_commit = 1'b1;
          cmd.res_set      = 1'b1;
          cmd.res_status   = STAT_OK;
        end else if (sts.scan_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = STAT_NOMEM;
        end else begin
          cmd.ptr_next = 1'b1;
        end
      end
      ST_RESP: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  // state register, reset starts the map build without a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_START;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/page_bitmap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Physical page frame allocator over a one-bit-per-page used map: init
// rebuilds the map from the memory size register, allocate hands out the
// lowest free page above the reserved area, free returns a used page.
// ----------------------------------------------------------------------------
//  channel  ports                       direction  carries
//  input    in_valid in_ready in_data   in         func, page_address
//  result   out_valid out_ready out_data out       status, address, counts
//  config   cfg_we cfg_wdata            in         memory_bytes
//
// One item at a time; the used map is read and written one word at a time
// through the word pointer. Init divides the memory size into pages, then
// writes one map word per cycle. Free divides the address into a page, then
// reads its word and clears a set bit; a page out of range is rejected.
// Allocate scans map words from the lowest word that may hold a free page.
// An unused code goes straight to its result. After reset the block builds
// the map for the reset memory size with in_ready low and no result.
// A result waits in the output register; the next item is taken meanwhile,
// and its result holds in_ready low until the waiting one transfers.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
  parameter int NUM_PAGES      = 32768,
  parameter int PAGE_BYTES     = 4096,
  parameter int RESERVED_PAGES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pba_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pba_pkg::out_item_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata
);
  import pba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // map, counters and result path
  pba_dp #(
    .NUM_PAGES      (NUM_PAGES),
    .PAGE_BYTES     (PAGE_BYTES),
    .RESERVED_PAGES (RESERVED_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a result never overwrites one that is still waiting
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending transfer");

  // at most one map update per cycle
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.sweep_wr, cmd.free_commit, cmd.alloc_commit}))
    else $error("conflicting map writes");

  // an accepted item blocks the input until its work is done
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  // a committed allocation always produces its result
  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_commit |-> (cmd.res_set && cmd.res_status == STAT_OK))
    else $error("allocation without result");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page bitmap allocator. Requests pass through a
// queue into a clocked driver, and a shadow copy of the used map predicts
// each result when its request transfers. A clocked monitor compares every
// result transfer, field by field, with the oldest prediction. The memory
// size register is changed between phases while the block is idle. Both
// channels idle at random outside steady phases, and the result side holds
// off twice long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
  import pba_pkg::*;

  localparam int NUM_PAGES      = 32768;
  localparam int PAGE_BYTES     = 4096;
  localparam int RESERVED_PAGES = 1024;
  // worst single wait is a full map scan or an init sweep plus a long stall
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int STALL_CYCLES   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // requests waiting for the driver, results owed by the block
  in_item_t  req_queue[$];
  out_item_t owed_results[$];

  // shadow of the allocator state
  bit          shadow_used[NUM_PAGES];
  int          shadow_total;
  int          shadow_free;
  logic [31:0] shadow_mem_bytes;

  int unsigned phase_top = NUM_PAGES;
  bit          steady = 1'b0;
  int          errors = 0;
  int          results_seen = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  page_bitmap_allocator #(
    .NUM_PAGES      (NUM_PAGES),
    .PAGE_BYTES     (PAGE_BYTES),
    .RESERVED_PAGES (RESERVED_PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // rebuild the shadow map from the memory size register
  function automatic void rebuild_shadow_map();
    logic [31:0] pages;
    pages = shadow_mem_bytes / PAGE_BYTES;
    if (pages > NUM_PAGES) pages = NUM_PAGES;
    shadow_total = int'(pages);
    shadow_free = 0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      shadow_used[i] = (i < RESERVED_PAGES) || (i >= shadow_total);
      if (!shadow_used[i]) shadow_free++;
    end
  endfunction

  // apply one request to the shadow state and return the result it owes
  function automatic out_item_t book_request(input in_item_t req);
    out_item_t   res;
    logic [31:0] page;
    bit          found;
    res = '0;
    res.status = STAT_OK;
    found = 1'b0;
    case (req.func)
      FUNC_INIT: rebuild_shadow_map();
      FUNC_ALLOC: begin
        // lowest free page above the reserved area
        for (int i = RESERVED_PAGES; i < shadow_total && !found; i++) begin
          if (!shadow_used[i]) begin
            shadow_used[i] = 1'b1;
            shadow_free--;
            res.alloc_address = 32'(i) * 32'(PAGE_BYTES);
            found = 1'b1;
          end
        end
        if (!found) res.status = STAT_NOMEM;
      end
      FUNC_FREE: begin
        page = req.page_address / PAGE_BYTES;
        res.status = STAT_REJECT;
        if (page < 32'(shadow_total)) begin
          if (shadow_used[page]) begin
            shadow_used[page] = 1'b0;
            shadow_free++;
            res.status = STAT_OK;
          end
        end
      end
      default: ;
    endcase
    res.free_count  = 16'(shadow_free);
    res.total_count = 16'(shadow_total);
    return res;
  endfunction

  function automatic in_item_t random_request(input int unsigned top_page);
    in_item_t    req;
    int unsigned pick;
    int unsigned page;
    pick = $urandom_range(0, 99);
    req.page_address = $urandom();
    page = 0;
    if (pick < 2) begin
      req.func = FUNC_INIT;
    end else if (pick < 7) begin
      req.func = FUNC_NOP;
    end else if (pick < 52) begin
      req.func = FUNC_ALLOC;
    end else begin
      req.func = FUNC_FREE;
      pick = $urandom_range(0, 99);
      // mostly pages that allocate is likely to have handed out
      if (pick < 70) page = RESERVED_PAGES + $urandom_range(0, 95);
      else if (pick < 80) page = $urandom_range(0, RESERVED_PAGES - 1);
      else if (pick < 90) page = top_page + $urandom_range(0, 2) - 1;
      if (pick < 90)
        req.page_address = page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
    end
    return req;
  endfunction

  task automatic queue_op(input func_t f, input logic [31:0] addr);
    in_item_t req;
    req.func = f;
    req.page_address = addr;
    req_queue.push_back(req);
  endtask

  // wait until every request has transferred and every result came back
  task automatic drain();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_valid || owed_results.size() != 0);
  endtask

  // new memory size while idle, then rebuild the map
  task automatic start_phase(input logic [31:0] mem_bytes);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mem_bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    shadow_mem_bytes = mem_bytes;
    phase_top = mem_bytes / PAGE_BYTES;
    if (phase_top > NUM_PAGES) phase_top = NUM_PAGES;
    queue_op(FUNC_INIT, $urandom());
  endtask

  task automatic random_phase(input logic [31:0] mem_bytes, input int count,
                              input bit calm);
    start_phase(mem_bytes);
    steady = calm;
    repeat (count) req_queue.push_back(random_request(phase_top));
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
               $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // request driver: predict on each transfer, then offer the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) owed_results.push_back(book_request(in_data));
      if (!in_valid || in_ready) begin
        if (req_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
          in_data  <= req_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure and two long hold-offs
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_data);
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("alloc_address", want.alloc_address, out_data.alloc_address);
          check_field("free_count", 32'(want.free_count), 32'(out_data.free_count));
          check_field("total_count", 32'(want.total_count),
                      32'(out_data.total_count));
        end
      end
      if (out_valid && out_ready && (results_seen == 200 || results_seen == 650)) begin
        stall_left <= STALL_CYCLES;
        out_ready  <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    shadow_mem_bytes = MEM_BYTES_RESET;
    rebuild_shadow_map();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset map: allocate, double free, reserved page, out of range, unused code
    queue_op(FUNC_ALLOC, 32'h0);
    queue_op(FUNC_ALLOC, 32'hFFFF_FFFF);
    queue_op(FUNC_FREE, 32'(RESERVED_PAGES * PAGE_BYTES) + 32'd5);
    queue_op(FUNC_FREE, 32'(RESERVED_PAGES * PAGE_BYTES));
    queue_op(FUNC_FREE, 32'h0);
    queue_op(FUNC_FREE, 32'h0000_0FFF);
    queue_op(FUNC_FREE, 32'hFFFF_FFFF);
    queue_op(FUNC_FREE, 32'((NUM_PAGES - 1) * PAGE_BYTES));
    queue_op(FUNC_NOP, 32'hFFFF_FFFF);
    queue_op(FUNC_ALLOC, 32'h0);
    queue_op(FUNC_INIT, 32'h0);

    // nothing above the reserved area
    start_phase(32'(RESERVED_PAGES * PAGE_BYTES));
    queue_op(FUNC_ALLOC, 32'h0);
    queue_op(FUNC_FREE, 32'((RESERVED_PAGES - 1) * PAGE_BYTES));
    queue_op(FUNC_ALLOC, 32'h0);

    // empty memory
    start_phase(32'h0);
    queue_op(FUNC_ALLOC, 32'h0);
    queue_op(FUNC_FREE, 32'h0);
    queue_op(FUNC_NOP, 32'h0);

    // largest size, clamped to the map capacity
    start_phase(32'hFFFF_FFFF);
    queue_op(FUNC_ALLOC, 32'h0);
    queue_op(FUNC_FREE, 32'hFFFF_FFFF - 32'(NUM_PAGES * PAGE_BYTES) + 32'd1);

    // two free pages, run out
    start_phase(32'((RESERVED_PAGES + 2) * PAGE_BYTES));
    repeat (3) queue_op(FUNC_ALLOC, 32'h0);

    // random traffic over a range of memory sizes
    random_phase(MEM_BYTES_RESET, 150, 1'b0);
    random_phase(32'((RESERVED_PAGES + 64) * PAGE_BYTES + 2049), 120, 1'b1);
    random_phase(32'hFFFF_FFFF, 110, 1'b0);
    random_phase(32'(RESERVED_PAGES * PAGE_BYTES + PAGE_BYTES - 1), 40, 1'b0);
    random_phase(32'((RESERVED_PAGES + 1) * PAGE_BYTES), 60, 1'b0);
    random_phase(32'(NUM_PAGES * PAGE_BYTES), 110, 1'b0);
    random_phase($urandom_range(RESERVED_PAGES * PAGE_BYTES, 2 * NUM_PAGES * PAGE_BYTES),
                 130, 1'b0);
    random_phase(32'h0, 30, 1'b0);
    random_phase(32'((RESERVED_PAGES + 200) * PAGE_BYTES), 150, 1'b0);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
